FILE: rtl/stl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and token kind codes for the script token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

    typedef logic [5:0] kind_t;
    typedef logic [7:0] byte_t;

    localparam int KW_MAX_LEN = 8;

    typedef byte_t [KW_MAX_LEN-1:0] kw_word_t;

    localparam kind_t K_IDENT   = 6'd0;
    localparam kind_t K_NUMBER  = 6'd1;
    localparam kind_t K_KW0     = 6'd2;
    localparam kind_t K_LPAREN  = 6'd23;
    localparam kind_t K_RPAREN  = 6'd24;
    localparam kind_t K_LBRACE  = 6'd25;
    localparam kind_t K_RBRACE  = 6'd26;
    localparam kind_t K_LBRACK  = 6'd27;
    localparam kind_t K_RBRACK  = 6'd28;
    localparam kind_t K_SEMI    = 6'd29;
    localparam kind_t K_COMMA   = 6'd30;
    localparam kind_t K_NE      = 6'd31;
    localparam kind_t K_BANG    = 6'd32;
    localparam kind_t K_HASH    = 6'd33;
    localparam kind_t K_PLUS    = 6'd34;
    localparam kind_t K_MINUS   = 6'd35;
    localparam kind_t K_STAR    = 6'd36;
    localparam kind_t K_SLASH   = 6'd37;
    localparam kind_t K_EQEQ    = 6'd38;
    localparam kind_t K_EQ      = 6'd39;
    localparam kind_t K_LE      = 6'd40;
    localparam kind_t K_LT      = 6'd41;
    localparam kind_t K_GE      = 6'd42;
    localparam kind_t K_GT      = 6'd43;
    localparam kind_t K_ILLEGAL = 6'd44;
    localparam kind_t K_END     = 6'd45;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] start;
        logic [15:0] length;
        logic        number_error;
        logic        last_of_run;
    } token_t;

endpackage

FILE: rtl/stl_kw_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_kw_match
// Parallel keyword comparators: maps a finished identifier to its kind.
// ----------------------------------------------------------------------------
module stl_kw_match (
    input  stl_pkg::kw_word_t word,
    input  logic [15:0]       word_length,
    input  logic              word_too_long,
    output stl_pkg::kind_t    word_kind
);

    localparam int KW_COUNT = 21;

    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        "and", "break", "do", "else", "elseif", "end", "false", "for",
        "function", "if", "in", "local", "nil", "not", "or", "repeat",
        "return", "then", "true", "until", "while"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd2, 4'd4, 4'd6, 4'd3, 4'd5, 4'd3,
        4'd8, 4'd2, 4'd2, 4'd5, 4'd3, 4'd3, 4'd2, 4'd6,
        4'd6, 4'd4, 4'd4, 4'd5, 4'd5
    };

    always_comb begin
        logic       hit;
        logic [2:0] pos;
        word_kind = stl_pkg::K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            hit = (word_length == 16'(KW_LEN[i])) && !word_too_long;
            for (int j = 0; j < stl_pkg::KW_MAX_LEN; j++) begin
                pos = 3'(int'(KW_LEN[i]) - 1 - j);
                if (j < int'(KW_LEN[i])) begin
                    hit = hit && (word[j] == KW_TEXT[i][pos*8 +: 8]);
                end
            end
            if (hit && word_kind == stl_pkg::K_IDENT) begin
                word_kind = stl_pkg::kind_t'(stl_pkg::K_KW0 + 6'(i));
            end
        end
    end

endmodule

FILE: rtl/stl_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_scan
// Scan state and token assembly: up to two tokens per accepted byte.
// ----------------------------------------------------------------------------
module stl_scan #(
    parameter int KEYWORD_CHARS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_accept,
    input  logic [7:0]       in_byte,
    input  logic             in_end,
    output stl_pkg::token_t  tok0,
    output stl_pkg::token_t  tok1,
    output logic [1:0]       tok_count
);

    localparam int IDX_W = $clog2(KEYWORD_CHARS);

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_IDENT  = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_TILDE  = 3'd3;
    localparam logic [2:0] MODE_EQ     = 3'd4;
    localparam logic [2:0] MODE_LT     = 3'd5;
    localparam logic [2:0] MODE_GT     = 3'd6;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_white(logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic stl_pkg::kind_t sym_kind(logic [7:0] c);
        stl_pkg::kind_t k;
        unique case (c)
            "(":     k = stl_pkg::K_LPAREN;
            ")":     k = stl_pkg::K_RPAREN;
            "{":     k = stl_pkg::K_LBRACE;
            "}":     k = stl_pkg::K_RBRACE;
            "[":     k = stl_pkg::K_LBRACK;
            "]":     k = stl_pkg::K_RBRACK;
            ";":     k = stl_pkg::K_SEMI;
            ",":     k = stl_pkg::K_COMMA;
            "!":     k = stl_pkg::K_BANG;
            "#":     k = stl_pkg::K_HASH;
            "+":     k = stl_pkg::K_PLUS;
            "-":     k = stl_pkg::K_MINUS;
            "*":     k = stl_pkg::K_STAR;
            "/":     k = stl_pkg::K_SLASH;
            default: k = stl_pkg::K_ILLEGAL;
        endcase
        return k;
    endfunction

    logic [2:0]  mode_reg, mode_next;
    logic [15:0] run_len_reg, run_len_next;
    logic [31:0] run_start_reg, run_start_next;
    logic [31:0] pos_reg, pos_next;
    logic        dot_seen_reg, dot_seen_next;
    logic        dot_err_reg, dot_err_next;
    logic        too_long_reg, too_long_next;
    logic [7:0]  word_reg [KEYWORD_CHARS];

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    stl_pkg::kw_word_t kw_word;
    stl_pkg::kind_t    kw_kind;
    stl_pkg::token_t   flush_tok, pend_tok, beg_tok;
    logic             pend_v, beg_v, keep, skip;
    logic [15:0]      run_len_inc;

    always_comb begin
        for (int j = 0; j < stl_pkg::KW_MAX_LEN; j++) begin
            kw_word[j] = word_reg[j];
        end
    end

    stl_kw_match u_kw_match (
        .word          (kw_word),
        .word_length   (run_len_reg),
        .word_too_long (too_long_reg),
        .word_kind     (kw_kind)
    );

    assign run_len_inc = (run_len_reg == 16'hFFFF) ? run_len_reg : run_len_reg + 16'd1;

    always_comb begin
        flush_tok              = '0;
        flush_tok.start        = run_start_reg;
        flush_tok.length       = 16'd1;
        flush_tok.kind         = stl_pkg::K_ILLEGAL;
        unique case (mode_reg)
            MODE_IDENT: begin
                flush_tok.kind   = kw_kind;
                flush_tok.length = run_len_reg;
            end
            MODE_NUMBER: begin
                flush_tok.kind         = stl_pkg::K_NUMBER;
                flush_tok.length       = run_len_reg;
                flush_tok.number_error = dot_err_reg;
            end
            MODE_EQ:  flush_tok.kind = stl_pkg::K_EQ;
            MODE_LT:  flush_tok.kind = stl_pkg::K_LT;
            MODE_GT:  flush_tok.kind = stl_pkg::K_GT;
            default:  flush_tok.kind = stl_pkg::K_ILLEGAL;
        endcase
    end

    always_comb begin
        mode_next      = mode_reg;
        run_len_next   = run_len_reg;
        run_start_next = run_start_reg;
        pos_next       = pos_reg;
        dot_seen_next  = dot_seen_reg;
        dot_err_next   = dot_err_reg;
        too_long_next  = too_long_reg;
        wr_en          = 1'b0;
        wr_idx         = '0;
        pend_v         = 1'b0;
        pend_tok       = flush_tok;
        beg_v          = 1'b0;
        beg_tok        = '0;
        beg_tok.start  = pos_reg;
        beg_tok.length = 16'd1;
        beg_tok.kind   = sym_kind(in_byte);
        keep           = 1'b0;
        skip           = 1'b0;
        if (in_accept) begin
            if (in_end) begin
                pend_v         = (mode_reg != MODE_IDLE);
                beg_v          = 1'b1;
                beg_tok.kind   = stl_pkg::K_END;
                beg_tok.length = 16'd0;
                mode_next      = MODE_IDLE;
            end else begin
                pos_next = pos_reg + 32'd1;
                unique case (mode_reg) inside
                    MODE_IDENT: begin
                        if (is_letter(in_byte) || is_num(in_byte) || in_byte == "_") begin
                            keep = 1'b1;
                            if (run_len_reg < 16'(KEYWORD_CHARS)) begin
                                wr_en  = 1'b1;
                                wr_idx = run_len_reg[IDX_W-1:0];
                            end else begin
                                too_long_next = 1'b1;
                            end
                            run_len_next = run_len_inc;
                        end else begin
                            pend_v = 1'b1;
                        end
                    end
                    MODE_NUMBER: begin
                        if (is_num(in_byte) || in_byte == ".") begin
                            keep = 1'b1;
                            if (in_byte == ".") begin
                                if (dot_seen_reg) begin
                                    dot_err_next = 1'b1;
                                end else begin
                                    dot_seen_next = 1'b1;
                                end
                            end
                            run_len_next = run_len_inc;
                        end else begin
                            pend_v = 1'b1;
                        end
                    end
                    MODE_TILDE, MODE_EQ, MODE_LT, MODE_GT: begin
                        pend_v = 1'b1;
                        if (in_byte == "=") begin
                            skip            = 1'b1;
                            pend_tok.length = 16'd2;
                            unique case (mode_reg)
                                MODE_TILDE: pend_tok.kind = stl_pkg::K_NE;
                                MODE_EQ:    pend_tok.kind = stl_pkg::K_EQEQ;
                                MODE_LT:    pend_tok.kind = stl_pkg::K_LE;
                                default:    pend_tok.kind = stl_pkg::K_GE;
                            endcase
                        end
                    end
                    default: ;
                endcase
                if (!keep) begin
                    mode_next = MODE_IDLE;
                    if (!skip && !is_white(in_byte)) begin
                        run_start_next = pos_reg;
                        run_len_next   = 16'd1;
                        if (is_letter(in_byte) || in_byte == "_") begin
                            mode_next     = MODE_IDENT;
                            wr_en         = 1'b1;
                            too_long_next = 1'b0;
                        end else if (is_num(in_byte)) begin
                            mode_next     = MODE_NUMBER;
                            dot_seen_next = 1'b0;
                            dot_err_next  = 1'b0;
                        end else if (in_byte == "~") begin
                            mode_next = MODE_TILDE;
                        end else if (in_byte == "=") begin
                            mode_next = MODE_EQ;
                        end else if (in_byte == "<") begin
                            mode_next = MODE_LT;
                        end else if (in_byte == ">") begin
                            mode_next = MODE_GT;
                        end else begin
                            beg_v = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        tok_count        = {1'b0, pend_v} + {1'b0, beg_v};
        tok0             = pend_v ? pend_tok : beg_tok;
        tok0.last_of_run = !(pend_v && beg_v);
        tok1             = beg_tok;
        tok1.last_of_run = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            run_len_reg   <= '0;
            run_start_reg <= '0;
            pos_reg       <= '0;
            dot_seen_reg  <= 1'b0;
            dot_err_reg   <= 1'b0;
            too_long_reg  <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            run_len_reg   <= run_len_next;
            run_start_reg <= run_start_next;
            pos_reg       <= pos_next;
            dot_seen_reg  <= dot_seen_next;
            dot_err_reg   <= dot_err_next;
            too_long_reg  <= too_long_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            word_reg[wr_idx] <= in_byte;
        end
    end

endmodule

FILE: rtl/stl_tok_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_tok_fifo
// Four-entry result queue: takes up to two tokens per cycle, gives one per pop.
// ----------------------------------------------------------------------------
module stl_tok_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      push_count,
    input  stl_pkg::token_t push0,
    input  stl_pkg::token_t push1,
    input  logic            pop,
    output stl_pkg::token_t head,
    output logic            not_empty,
    output logic            has_room
);

    stl_pkg::token_t mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 2'd1;
    assign wr_ptr_next  = wr_ptr_reg + push_count;
    assign rd_ptr_next  = rd_ptr_reg + {1'b0, pop};
    assign count_next   = count_reg + {1'b0, push_count} - {2'b00, pop};

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != 3'd0);
    assign has_room  = (count_reg <= 3'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push1;
        end
    end

endmodule

FILE: rtl/script_token_lexer_unit.sv
`timescale 1ns / 1ps
// Token path: each finished token enters the result queue and leaves on m_ after
// any tokens queued ahead; a two-token transaction queues its tokens in order.
// Throughput: one transaction per cycle while s_tready is high; s_tready drops
// only while the four-entry result queue holds three or more tokens.
// Reset: synchronous active-low aresetn clears scan state, offset and queue.
// ----------------------------------------------------------------------------
// script_token_lexer_unit
// Streaming tokenizer: bytes in, kind/start/length tokens out.
// ----------------------------------------------------------------------------
module script_token_lexer_unit #(
    parameter int KEYWORD_CHARS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] token_start, [47:32] token_length,
                                   // [48] number_error
    output logic [5:0]  m_tuser,   // [5:0] token_kind
    output logic        m_tlast    // last_of_run
);

    logic            in_accept;
    logic            pop;
    logic [1:0]      tok_count;
    stl_pkg::token_t tok0, tok1, head;

    assign in_accept = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;

    stl_scan #(
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .tok0      (tok0),
        .tok1      (tok1),
        .tok_count (tok_count)
    );

    stl_tok_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (tok_count),
        .push0      (tok0),
        .push1      (tok1),
        .pop        (pop),
        .head       (head),
        .not_empty  (m_tvalid),
        .has_room   (s_tready)
    );

    assign m_tdata = {7'b0, head.number_error, head.length, head.start};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;

endmodule

FILE: rtl/stl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_checker
// Port-level checks on the token stream of the lexer.
// ----------------------------------------------------------------------------
module stl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [5:0]  m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= stl_pkg::K_END)
        else $error("token kind out of range");

    a_end_token: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == stl_pkg::K_END |->
            m_tlast && m_tdata[47:32] == 16'd0 && !m_tdata[48])
        else $error("malformed end token");

    a_dot_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[48] |-> m_tuser == stl_pkg::K_NUMBER)
        else $error("number error on non-number token");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind script_token_lexer_unit stl_checker u_stl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
